// ===== rtl/gelt_pkg.sv =====
// shared types and codes for the gpio edge listener table
package gelt_pkg;

    localparam int PIN_W   = 10;
    localparam int OWNER_W = 8;
    localparam int STAMP_W = 63;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_EVENT = 2'd1,
        OP_ERROR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_RISING  = 2'd1,
        MODE_FALLING = 2'd2,
        MODE_BOTH    = 2'd3
    } mode_t;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [PIN_W-1:0]   pin;
        logic [1:0]         trig_mode;
        logic               suppress;
        logic [OWNER_W-1:0] owner;
        logic               level;
        logic [STAMP_W-1:0] stamp;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [PIN_W-1:0]   report_pin;
        logic [OWNER_W-1:0] report_owner;
        logic [STAMP_W-1:0] report_stamp;
        logic               report_level;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [PIN_W-1:0]   pin;
        logic [1:0]         mode;
        logic               suppress;
        logic [OWNER_W-1:0] owner;
        logic               known;
        logic               lastval;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_EMIT1 = 5'b01000,
        ST_EMIT2 = 5'b10000
    } state_t;

endpackage

// ===== rtl/gelt_store.sv =====
// listener entry memory: one write port, one registered read port
module gelt_store #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  gelt_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output gelt_pkg::entry_t rd_data
);

    gelt_pkg::entry_t mem [DEPTH];
    gelt_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gpio_edge_listener_table.sv =====
// gpio edge listener table: top level with sequencer and output register
//
// s_ channel takes one item (set listener, pin event, read error); s_ready is
// high only while the sequencer is idle and out of reset. m_ channel carries
// results, the last one of each item flagged by last. Results sit in an output
// register, so a new item may be taken while the final result still waits.
// Entries live in a small memory kept packed at the low end; a fill count
// marks the valid ones, so reset needs no clearing pass and the block is
// ready as soon as aresetn goes high.
// Per item: the idle state takes the transfer, then the lookup walks the
// memory one entry a cycle, stopping on a hit or after count entries. A
// removal then moves the later entries down one per cycle. Each result is
// then loaded into the output register.
// A stalled receiver holds the sequencer in its result state until the
// output register frees up.
module gpio_edge_listener_table #(
    parameter int LISTENERS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gelt_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gelt_pkg::out_item_t   m_data
);

    localparam int IW = (LISTENERS > 1) ? $clog2(LISTENERS) : 1;
    localparam int CW = $clog2(LISTENERS + 1);

    gelt_pkg::state_t    state_reg, state_next;
    gelt_pkg::in_item_t  item_reg, item_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    gelt_pkg::out_item_t pend_reg, pend_next;
    logic                two_reg, two_next;
    logic                m_valid_reg, m_valid_next;
    gelt_pkg::out_item_t m_data_reg, m_data_next;

    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    gelt_pkg::entry_t    wr_data;
    gelt_pkg::entry_t    rd_data;
    gelt_pkg::entry_t    new_entry;
    gelt_pkg::out_item_t edge_rep;
    logic                at_end;
    logic                hit;
    logic                slot_free;

    gelt_store #(.DEPTH(LISTENERS)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next[IW-1:0]),
        .rd_data (rd_data)
    );

    assign at_end    = (idx_reg >= count_reg);
    assign hit       = !at_end && (rd_data.pin == item_reg.pin);
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        new_entry          = '0;
        new_entry.pin      = item_reg.pin;
        new_entry.mode     = item_reg.trig_mode;
        new_entry.suppress = item_reg.suppress;
        new_entry.owner    = item_reg.owner;
        new_entry.known    = 1'b0;
        new_entry.lastval  = 1'b0;

        edge_rep              = '0;
        edge_rep.kind         = gelt_pkg::KIND_EDGE;
        edge_rep.report_pin   = rd_data.pin;
        edge_rep.report_owner = rd_data.owner;
        edge_rep.report_stamp = item_reg.stamp;
        edge_rep.report_level = item_reg.level;
        edge_rep.last         = 1'b1;
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        pend_next    = pend_reg;
        two_next     = two_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[IW-1:0];
        wr_data      = new_entry;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            gelt_pkg::ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid) begin
                    item_next  = s_data;
                    idx_next   = '0;
                    state_next = gelt_pkg::ST_SCAN;
                end
            end
            gelt_pkg::ST_SCAN: begin
                two_next = 1'b0;
                if (at_end) begin
                    state_next = gelt_pkg::ST_IDLE;
                    if (item_reg.op == gelt_pkg::OP_SET
                            && item_reg.trig_mode != gelt_pkg::MODE_NONE) begin
                        if (count_reg == CW'(LISTENERS)) begin
                            pend_next              = '0;
                            pend_next.kind         = gelt_pkg::KIND_FULL;
                            pend_next.report_pin   = item_reg.pin;
                            pend_next.report_owner = item_reg.owner;
                            pend_next.last         = 1'b1;
                            state_next             = gelt_pkg::ST_EMIT1;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IW-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                end else if (hit) begin
                    state_next = gelt_pkg::ST_IDLE;
                    case (item_reg.op)
                        gelt_pkg::OP_SET: begin
                            if (item_reg.trig_mode == gelt_pkg::MODE_NONE) begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = gelt_pkg::ST_SHIFT;
                            end else begin
                                wr_en = 1'b1;
                            end
                        end
                        gelt_pkg::OP_ERROR: begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = gelt_pkg::ST_SHIFT;
                        end
                        gelt_pkg::OP_EVENT: begin
                            pend_next = edge_rep;
                            case (rd_data.mode)
                                gelt_pkg::MODE_RISING: begin
                                    pend_next.report_level = 1'b1;
                                    if (item_reg.level || !rd_data.suppress) begin
                                        state_next = gelt_pkg::ST_EMIT1;
                                    end
                                end
                                gelt_pkg::MODE_FALLING: begin
                                    pend_next.report_level = 1'b0;
                                    if (!item_reg.level || !rd_data.suppress) begin
                                        state_next = gelt_pkg::ST_EMIT1;
                                    end
                                end
                                gelt_pkg::MODE_BOTH: begin
                                    if (!rd_data.known || rd_data.lastval != item_reg.level) begin
                                        // change seen: report it and remember the level
                                        wr_en           = 1'b1;
                                        wr_data         = rd_data;
                                        wr_data.known   = 1'b1;
                                        wr_data.lastval = item_reg.level;
                                        state_next      = gelt_pkg::ST_EMIT1;
                                    end else if (!rd_data.suppress) begin
                                        // glitch: inverse level, then the level
                                        pend_next.report_level = ~item_reg.level;
                                        pend_next.last         = 1'b0;
                                        two_next               = 1'b1;
                                        state_next             = gelt_pkg::ST_EMIT1;
                                    end
                                end
                                default: begin
                                    state_next = gelt_pkg::ST_IDLE;
                                end
                            endcase
                        end
                        default: begin
                            state_next = gelt_pkg::ST_IDLE;
                        end
                    endcase
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            gelt_pkg::ST_SHIFT: begin
                // idx_reg is the source slot, its data sits in rd_data
                if (at_end) begin
                    count_next = count_reg - 1'b1;
                    state_next = gelt_pkg::ST_IDLE;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = IW'(idx_reg - 1'b1);
                    wr_data  = rd_data;
                    idx_next = idx_reg + 1'b1;
                end
            end
            gelt_pkg::ST_EMIT1: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = two_reg ? gelt_pkg::ST_EMIT2 : gelt_pkg::ST_IDLE;
                end
            end
            gelt_pkg::ST_EMIT2: begin
                if (slot_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next               = pend_reg;
                    m_data_next.report_level  = item_reg.level;
                    m_data_next.last          = 1'b1;
                    state_next                = gelt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gelt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gelt_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            two_reg     <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            two_reg     <= two_next;
            idx_reg     <= idx_next;
        end
        item_reg   <= item_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/gelt_checker.sv =====
// checker for the gpio edge listener table: listener model plus result comparison
module gelt_checker #(
    parameter int LISTENERS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  gelt_pkg::in_item_t            s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  gelt_pkg::out_item_t           m_data,
    output int                            fail_count,
    output int                            pending,
    output int                            reports_checked,
    output int                            full_seen,
    output int                            pairs_seen
);

    typedef struct packed {
        logic [gelt_pkg::PIN_W-1:0]   pin;
        gelt_pkg::mode_t              mode;
        logic                         suppress;
        logic [gelt_pkg::OWNER_W-1:0] owner;
        logic                         known;
        logic                         lastval;
    } listener_t;

    listener_t           listeners [LISTENERS];
    int                  fill = 0;
    gelt_pkg::out_item_t report_q [$];

    int n_fail    = 0;
    int n_checked = 0;
    int n_full    = 0;
    int n_pairs   = 0;

    function automatic void push_report(logic kind, logic [gelt_pkg::PIN_W-1:0] pin,
                                        logic [gelt_pkg::OWNER_W-1:0] owner,
                                        logic [gelt_pkg::STAMP_W-1:0] stamp,
                                        logic level, logic last);
        gelt_pkg::out_item_t r;
        r.kind         = kind;
        r.report_pin   = pin;
        r.report_owner = owner;
        r.report_stamp = stamp;
        r.report_level = level;
        r.last         = last;
        report_q.push_back(r);
    endfunction

    // later entries close the gap so the table stays packed
    function automatic void drop_listener(int idx);
        for (int i = idx; i + 1 < fill; i++)
            listeners[i] = listeners[i + 1];
        fill--;
    endfunction

    function automatic void predict_reports(gelt_pkg::in_item_t it);
        int        hit;
        listener_t e;
        hit = -1;
        for (int i = 0; i < fill; i++)
            if (listeners[i].pin == it.pin)
                hit = i;
        case (gelt_pkg::op_t'(it.op))
            gelt_pkg::OP_SET: begin
                if (gelt_pkg::mode_t'(it.trig_mode) == gelt_pkg::MODE_NONE) begin
                    if (hit >= 0)
                        drop_listener(hit);
                end else begin
                    if (hit < 0 && fill < LISTENERS) begin
                        hit = fill;
                        fill++;
                    end
                    if (hit < 0) begin
                        push_report(gelt_pkg::KIND_FULL, it.pin, it.owner, '0, 1'b0, 1'b1);
                    end else begin
                        e.pin      = it.pin;
                        e.mode     = gelt_pkg::mode_t'(it.trig_mode);
                        e.suppress = it.suppress;
                        e.owner    = it.owner;
                        e.known    = 1'b0;
                        e.lastval  = 1'b0;
                        listeners[hit] = e;
                    end
                end
            end
            gelt_pkg::OP_ERROR: begin
                if (hit >= 0)
                    drop_listener(hit);
            end
            gelt_pkg::OP_EVENT: begin
                if (hit >= 0) begin
                    e = listeners[hit];
                    case (e.mode)
                        gelt_pkg::MODE_RISING: begin
                            if (it.level || !e.suppress)
                                push_report(gelt_pkg::KIND_EDGE, e.pin, e.owner, it.stamp,
                                            1'b1, 1'b1);
                        end
                        gelt_pkg::MODE_FALLING: begin
                            if (!it.level || !e.suppress)
                                push_report(gelt_pkg::KIND_EDGE, e.pin, e.owner, it.stamp,
                                            1'b0, 1'b1);
                        end
                        gelt_pkg::MODE_BOTH: begin
                            if (!e.known || e.lastval != it.level) begin
                                push_report(gelt_pkg::KIND_EDGE, e.pin, e.owner, it.stamp,
                                            it.level, 1'b1);
                                listeners[hit].known   = 1'b1;
                                listeners[hit].lastval = it.level;
                            end else if (!e.suppress) begin
                                // missed glitch: report the opposite level, then the current one
                                push_report(gelt_pkg::KIND_EDGE, e.pin, e.owner, it.stamp,
                                            ~it.level, 1'b0);
                                push_report(gelt_pkg::KIND_EDGE, e.pin, e.owner, it.stamp,
                                            it.level, 1'b1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        gelt_pkg::out_item_t want;
        if (!aresetn) begin
            fill = 0;
            report_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_data);
                    n_fail++;
                end else begin
                    want = report_q.pop_front();
                    n_checked++;
                    if (want.kind == gelt_pkg::KIND_FULL)
                        n_full++;
                    if (!want.last)
                        n_pairs++;
                    if (m_data.kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_data.kind);
                        n_fail++;
                    end
                    if (m_data.report_pin !== want.report_pin) begin
                        $error("report_pin: expected %0d, actual %0d",
                               want.report_pin, m_data.report_pin);
                        n_fail++;
                    end
                    if (m_data.report_owner !== want.report_owner) begin
                        $error("report_owner: expected %0d, actual %0d",
                               want.report_owner, m_data.report_owner);
                        n_fail++;
                    end
                    if (m_data.report_stamp !== want.report_stamp) begin
                        $error("report_stamp: expected %0d, actual %0d",
                               want.report_stamp, m_data.report_stamp);
                        n_fail++;
                    end
                    if (m_data.report_level !== want.report_level) begin
                        $error("report_level: expected %0d, actual %0d",
                               want.report_level, m_data.report_level);
                        n_fail++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_data.last);
                        n_fail++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_reports(s_data);
        end
        fail_count      <= n_fail;
        pending         <= report_q.size();
        reports_checked <= n_checked;
        full_seen       <= n_full;
        pairs_seen      <= n_pairs;
    end

endmodule

// ===== tb/gpio_edge_listener_table_tb.sv =====
// testbench top for the gpio edge listener table: stimulus, receiver and verdict
module gpio_edge_listener_table_tb;

    localparam int LISTENERS   = 16;
    localparam int ITEMS       = 1350;
    localparam int LIMIT       = 1_200_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 2 * LISTENERS + 8;
    localparam int POOL        = 24;

    typedef logic [gelt_pkg::PIN_W-1:0]   pin_t;
    typedef logic [gelt_pkg::OWNER_W-1:0] owner_t;
    typedef logic [gelt_pkg::STAMP_W-1:0] stamp_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                m_ready = 1'b0;
    gelt_pkg::in_item_t  s_data  = '0;
    logic                s_ready;
    logic                m_valid;
    gelt_pkg::out_item_t m_data;

    int fail_count;
    int pending;
    int reports_checked;
    int full_seen;
    int pairs_seen;

    int cycles      = 0;
    int items_sent  = 0;
    int hold_asked  = 0;
    int hold_done   = 0;
    int burst_left  = 0;

    pin_t pin_pool [POOL];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    gpio_edge_listener_table #(
        .LISTENERS(LISTENERS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    gelt_checker #(
        .LISTENERS(LISTENERS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .reports_checked (reports_checked),
        .full_seen       (full_seen),
        .pairs_seen      (pairs_seen)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAIL gpio_edge_listener_table");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic stamp_t any_stamp();
        logic [63:0] w;
        int          r;
        r = $urandom_range(0, 9);
        w = {$urandom(), $urandom()};
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return w[gelt_pkg::STAMP_W-1:0];
    endfunction

    function automatic gelt_pkg::in_item_t any_item();
        gelt_pkg::in_item_t it;
        it.op        = 2'($urandom_range(0, 3));
        it.pin       = pin_t'($urandom_range(0, 1023));
        it.trig_mode = 2'($urandom_range(0, 3));
        it.suppress  = 1'($urandom_range(0, 1));
        it.owner     = owner_t'($urandom_range(0, 255));
        it.level     = 1'($urandom_range(0, 1));
        it.stamp     = any_stamp();
        return it;
    endfunction

    // unused fields keep random content
    function automatic gelt_pkg::in_item_t set_item(pin_t pin, gelt_pkg::mode_t mode,
                                                    logic sup, owner_t owner);
        gelt_pkg::in_item_t it;
        it           = any_item();
        it.op        = gelt_pkg::OP_SET;
        it.pin       = pin;
        it.trig_mode = mode;
        it.suppress  = sup;
        it.owner     = owner;
        return it;
    endfunction

    function automatic gelt_pkg::in_item_t event_item(pin_t pin, logic level, stamp_t stamp);
        gelt_pkg::in_item_t it;
        it       = any_item();
        it.op    = gelt_pkg::OP_EVENT;
        it.pin   = pin;
        it.level = level;
        it.stamp = stamp;
        return it;
    endfunction

    function automatic gelt_pkg::in_item_t op_item(gelt_pkg::op_t op, pin_t pin);
        gelt_pkg::in_item_t it;
        it     = any_item();
        it.op  = op;
        it.pin = pin;
        return it;
    endfunction

    function automatic pin_t pool_pin();
        return pin_pool[$urandom_range(0, POOL - 1)];
    endfunction

    function automatic gelt_pkg::mode_t live_mode();
        return gelt_pkg::mode_t'($urandom_range(1, 3));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic owner_t any_owner();
        return owner_t'($urandom_range(0, 255));
    endfunction

    // valid is only lowered when a gap follows, so back-to-back items keep it high
    task automatic send_item(gelt_pkg::in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (gelt_pkg::op_t'(it.op) != gelt_pkg::OP_NONE)
            items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : receiver
        int r;
        @(posedge aclk);
        forever begin
            if (hold_asked != hold_done) begin
                hold_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end else if (r < 60) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(50, 200)) @(posedge aclk);
                end else if (r < 92) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(20, 80)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int   r;
        int   n;
        int   start;
        logic paused;
        logic filled_once;
        pin_t p;

        paused      = 1'b0;
        filled_once = 1'b0;
        // distinct pins spread over the whole range, both ends included
        pin_pool[0]        = '0;
        pin_pool[POOL - 1] = '1;
        for (int i = 1; i < POOL - 1; i++)
            pin_pool[i] = pin_t'(i * 44 + $urandom_range(0, 43));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // lookups that miss and the unused op
        send_item(event_item(10'd0, 1'b1, '1));
        send_item(op_item(gelt_pkg::OP_ERROR, 10'd0));
        send_item(set_item(10'd0, gelt_pkg::MODE_NONE, 1'b0, 8'h00));
        send_item(op_item(gelt_pkg::OP_NONE, 10'd1023));
        // rising, with and without suppression, then replaced in place
        send_item(set_item(10'd0, gelt_pkg::MODE_RISING, 1'b1, 8'h00));
        send_item(event_item(10'd0, 1'b1, '0));
        send_item(event_item(10'd0, 1'b0, any_stamp()));
        send_item(set_item(10'd0, gelt_pkg::MODE_RISING, 1'b0, 8'hFF));
        send_item(event_item(10'd0, 1'b0, '1));
        // falling
        send_item(set_item(10'd1023, gelt_pkg::MODE_FALLING, 1'b1, 8'hA5));
        send_item(event_item(10'd1023, 1'b1, any_stamp()));
        send_item(event_item(10'd1023, 1'b0, any_stamp()));
        send_item(set_item(10'd1023, gelt_pkg::MODE_FALLING, 1'b0, 8'h5A));
        send_item(event_item(10'd1023, 1'b1, any_stamp()));
        // both edges: unknown start, glitch pair, real change
        send_item(set_item(10'd5, gelt_pkg::MODE_BOTH, 1'b0, 8'h3C));
        send_item(event_item(10'd5, 1'b0, any_stamp()));
        send_item(event_item(10'd5, 1'b0, any_stamp()));
        send_item(event_item(10'd5, 1'b1, any_stamp()));
        // replacing forgets the last level; suppressed glitch
        send_item(set_item(10'd5, gelt_pkg::MODE_BOTH, 1'b1, 8'hC3));
        send_item(event_item(10'd5, 1'b1, any_stamp()));
        send_item(event_item(10'd5, 1'b1, any_stamp()));
        send_item(event_item(10'd5, 1'b0, any_stamp()));
        // drops by read error and by removal
        send_item(op_item(gelt_pkg::OP_ERROR, 10'd1023));
        send_item(event_item(10'd1023, 1'b0, any_stamp()));
        send_item(set_item(10'd0, gelt_pkg::MODE_NONE, 1'b1, 8'h00));
        send_item(event_item(10'd0, 1'b1, any_stamp()));
        drain();

        while (items_sent < ITEMS) begin
            if (items_sent >= 450 && hold_asked == 0)
                hold_asked++;
            if (items_sent >= 900 && !paused) begin
                drain();
                paused = 1'b1;
            end
            r = filled_once ? $urandom_range(0, 99) : 0;
            if (r < 6) begin
                // run of sets over consecutive pool pins, enough to fill the table
                filled_once = 1'b1;
                start = $urandom_range(0, POOL - 1);
                n = $urandom_range(16, 20);
                for (int k = 0; k < n; k++)
                    send_item(set_item(pin_pool[(start + k) % POOL], live_mode(),
                                       any_bit(), any_owner()));
            end else if (r < 50) begin
                p = pool_pin();
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_item(event_item(p, any_bit(), any_stamp()));
            end else if (r < 72) begin
                send_item(set_item(pool_pin(), live_mode(), any_bit(), any_owner()));
            end else if (r < 80) begin
                send_item(set_item(pool_pin(), gelt_pkg::MODE_NONE, any_bit(), any_owner()));
            end else if (r < 87) begin
                send_item(op_item(gelt_pkg::OP_ERROR, pool_pin()));
            end else if (r < 93) begin
                send_item(event_item(pin_t'($urandom_range(0, 1023)), any_bit(),
                                     any_stamp()));
            end else begin
                send_item(any_item());
            end
        end
        drain();

        $display("%0d items sent, %0d results checked", items_sent, reports_checked);
        $display("%0d table-full rejections, %0d glitch report pairs", full_seen, pairs_seen);
        if (fail_count == 0)
            $display("PASS gpio_edge_listener_table");
        else
            $display("FAIL gpio_edge_listener_table");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gelt_pkg.sv
rtl/gelt_store.sv
rtl/gpio_edge_listener_table.sv
tb/gelt_checker.sv
tb/gpio_edge_listener_table_tb.sv
